/* src/ple_pkg.sv */
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);

   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REPLACE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic                      empty_res;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [VALUE_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

endpackage

/* src/ple_ram.sv */
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/ple_ctrl.sv */
module ple_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ple_pkg::req_type             req_item,
   output logic                         rsp_valid,
   output ple_pkg::rsp_type             rsp_item,
   output ple_pkg::mem_req_type         mem_req,
   input  logic [ple_pkg::VALUE_W-1:0]  mem_rdata
);

   import ple_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_INS_SHIFT,
      S_INS_LAST,
      S_DEL_HEAD,
      S_DEL_SHIFT
   } state_type;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COUNT_W-1:0] count_dec;
   logic [COUNT_W-1:0] count_inc;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   last_idx;

   assign count_dec = count_ff - COUNT_W'(1);
   assign count_inc = count_ff + COUNT_W'(1);
   assign req_idx   = req_item.position[IDX_W-1:0];
   assign last_idx  = count_dec[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_req      = '0;
      mem_req.raddr = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in = req_idx;
               val_in = req_item.value_in;
               if (req_item.kind == KIND_INSERT) begin
                  priority if (req_item.position > count_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.value_out = '0;
                     rsp_in.status    = ST_RANGE;
                  end else if (count_ff >= CAP_COUNT) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.value_out = '0;
                     rsp_in.status    = ST_FULL;
                  end else if (req_item.position == count_ff) begin
                     // append: nothing to move
                     mem_req.we       = 1'b1;
                     mem_req.waddr    = req_idx;
                     mem_req.wdata    = req_item.value_in;
                     count_in         = count_inc;
                     rsp_valid_in     = 1'b1;
                     rsp_in.value_out = '0;
                     rsp_in.status    = ST_OK;
                  end else begin
                     mem_req.raddr = last_idx;
                     idx_in        = last_idx;
                     state_in      = S_INS_SHIFT;
                  end
               end else if (req_item.position >= count_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.value_out = '0;
                  rsp_in.status    = ST_RANGE;
               end else begin
                  unique case (req_item.kind)
                     KIND_DELETE: begin
                        mem_req.raddr = req_idx;
                        state_in      = S_DEL_HEAD;
                     end
                     KIND_RETRIEVE: begin
                        mem_req.raddr = req_idx;
                        state_in      = S_READ;
                     end
                     default: begin
                        mem_req.we       = 1'b1;
                        mem_req.waddr    = req_idx;
                        mem_req.wdata    = req_item.value_in;
                        rsp_valid_in     = 1'b1;
                        rsp_in.value_out = '0;
                        rsp_in.status    = ST_OK;
                     end
                  endcase
               end
            end
         end

         S_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.value_out = mem_rdata;
            rsp_in.status    = ST_OK;
            state_in         = S_IDLE;
         end

         // walk from the tail down, moving each entry one place up
         S_INS_SHIFT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff + IDX_W'(1);
            mem_req.wdata = mem_rdata;
            if (idx_ff == pos_ff) begin
               state_in = S_INS_LAST;
            end else begin
               mem_req.raddr = idx_ff - IDX_W'(1);
               idx_in        = idx_ff - IDX_W'(1);
            end
         end

         S_INS_LAST: begin
            mem_req.we       = 1'b1;
            mem_req.waddr    = pos_ff;
            mem_req.wdata    = val_ff;
            count_in         = count_inc;
            rsp_valid_in     = 1'b1;
            rsp_in.value_out = '0;
            rsp_in.status    = ST_OK;
            state_in         = S_IDLE;
         end

         S_DEL_HEAD: begin
            val_in = mem_rdata;
            if (pos_ff == last_idx) begin
               count_in         = count_dec;
               rsp_valid_in     = 1'b1;
               rsp_in.value_out = mem_rdata;
               rsp_in.status    = ST_OK;
               state_in         = S_IDLE;
            end else begin
               mem_req.raddr = pos_ff + IDX_W'(1);
               idx_in        = pos_ff + IDX_W'(1);
               state_in      = S_DEL_SHIFT;
            end
         end

         // close the gap: entry idx moves down one place
         S_DEL_SHIFT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff - IDX_W'(1);
            mem_req.wdata = mem_rdata;
            if (idx_ff == last_idx) begin
               count_in         = count_dec;
               rsp_valid_in     = 1'b1;
               rsp_in.value_out = val_ff;
               rsp_in.status    = ST_OK;
               state_in         = S_IDLE;
            end else begin
               mem_req.raddr = idx_ff + IDX_W'(1);
               idx_in        = idx_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.count     = count_in;
      rsp_in.empty_res = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while still working");

   a_count_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("count changed without a result");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (COUNT_W'(mem_req.waddr) <= count_ff))
      else $error("write beyond the end of the list");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count == count_ff))
      else $error("reported count differs from held count");
`endif

endmodule

/* src/positional_list_engine.sv */
// Channel   Ports                           Transfer
// request   start, busy, req_item           start high and busy low at a rising edge
// result    rsp_valid, rsp_item             rsp_valid high for one cycle, always taken
//
// A result appears in the cycle after the request finishes. Errors, replace and
// insert at the tail finish in the transfer cycle; retrieve keeps busy high
// while it reads, delete and insert while they shift the tail of the list,
// one memory entry moved per cycle through the single write port.
// Synchronous active-high reset empties the list; the stored entries keep their
// contents. The result side cannot stall.
module positional_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_item,
   output logic             rsp_valid,
   output ple_pkg::rsp_type rsp_item
);

   import ple_pkg::*;

   mem_req_type        mem_req;
   logic [VALUE_W-1:0] mem_rdata;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

endmodule
